// ===== rtl/dbsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dbsc_pkg
// Types and constants shared by the brake slew controller modules.
// ----------------------------------------------------------------------------
package dbsc_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Register indexes (byte address is four times the index).
	localparam logic [2:0] REG_ENABLE         = 3'd0;
	localparam logic [2:0] REG_GATE_SOURCE    = 3'd1;
	localparam logic [2:0] REG_SPEED_LIMIT    = 3'd2;
	localparam logic [2:0] REG_THROTTLE_LIMIT = 3'd3;
	localparam logic [2:0] REG_DEADZONE       = 3'd4;
	localparam logic [2:0] REG_MAX_FORCE      = 3'd5;
	localparam logic [2:0] REG_APPLY_RATE     = 3'd6;
	localparam logic [2:0] REG_RELEASE_RATE   = 3'd7;

	// Gate source codes.
	localparam logic [1:0] GATE_SPEED    = 2'd0;
	localparam logic [1:0] GATE_THROTTLE = 2'd1;

	// Reset values of the registers.
	localparam logic [15:0] RST_SPEED_LIMIT    = 16'd5927;
	localparam logic [15:0] RST_THROTTLE_LIMIT = 16'd16384;
	localparam logic [14:0] RST_DEADZONE       = 15'd1638;
	localparam logic [14:0] RST_MAX_FORCE      = 15'd2785;
	localparam logic [15:0] RST_APPLY_RATE     = 16'd8192;
	localparam logic [15:0] RST_RELEASE_RATE   = 16'd12288;

	// Both the divider and the square root produce 15 result bits.
	localparam logic [3:0]  LAST_ITER = 4'd14;
	localparam logic [29:0] SQ_BIT0   = 30'h1000_0000;

	typedef struct packed {
		logic        enable;
		logic [1:0]  gate_source;
		logic [15:0] speed_limit;
		logic [15:0] throttle_limit;
		logic [14:0] deadzone;
		logic [14:0] max_force;
		logic [15:0] apply_rate;
		logic [15:0] release_rate;
	} cfg_t;

	typedef struct packed {
		logic [15:0] rudder;
		logic        on_ground;
		logic [15:0] ground_speed;
		logic [15:0] throttle;
		logic [15:0] elapsed;
	} item_t;

	typedef struct packed {
		logic [14:0] left_brake;
		logic [14:0] right_brake;
		logic        braking_active;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic clr_bal;
		logic zero_prod;
		logic div_init;
		logic div_step;
		logic sq_init;
		logic sq_step;
		logic mul1;
		logic mul2;
		logic mul3;
		logic update;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic active;
		logic in_zone;
	} dp_stat_t;

endpackage

// ===== rtl/dbsc_regs.sv =====
// ----------------------------------------------------------------------------
// dbsc_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module dbsc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dbsc_pkg::ADDR_W-1:0]   paddr,
	input  logic [dbsc_pkg::DATA_W-1:0]   pwdata,
	output logic [dbsc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output dbsc_pkg::cfg_t                cfg
);
	import dbsc_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[4:2];
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable         <= 1'b0;
			cfg_q.gate_source    <= GATE_SPEED;
			cfg_q.speed_limit    <= RST_SPEED_LIMIT;
			cfg_q.throttle_limit <= RST_THROTTLE_LIMIT;
			cfg_q.deadzone       <= RST_DEADZONE;
			cfg_q.max_force      <= RST_MAX_FORCE;
			cfg_q.apply_rate     <= RST_APPLY_RATE;
			cfg_q.release_rate   <= RST_RELEASE_RATE;
		end else if (wr_en) begin
			case (idx)
				REG_ENABLE:         cfg_q.enable         <= pwdata[0];
				REG_GATE_SOURCE:    cfg_q.gate_source    <= pwdata[1:0];
				REG_SPEED_LIMIT:    cfg_q.speed_limit    <= pwdata[15:0];
				REG_THROTTLE_LIMIT: cfg_q.throttle_limit <= pwdata[15:0];
				REG_DEADZONE:       cfg_q.deadzone       <= pwdata[14:0];
				REG_MAX_FORCE:      cfg_q.max_force      <= pwdata[14:0];
				REG_APPLY_RATE:     cfg_q.apply_rate     <= pwdata[15:0];
				REG_RELEASE_RATE:   cfg_q.release_rate   <= pwdata[15:0];
				default:            cfg_q.enable         <= cfg_q.enable;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_ENABLE:         prdata = {31'd0, cfg_q.enable};
			REG_GATE_SOURCE:    prdata = {30'd0, cfg_q.gate_source};
			REG_SPEED_LIMIT:    prdata = {16'd0, cfg_q.speed_limit};
			REG_THROTTLE_LIMIT: prdata = {16'd0, cfg_q.throttle_limit};
			REG_DEADZONE:       prdata = {17'd0, cfg_q.deadzone};
			REG_MAX_FORCE:      prdata = {17'd0, cfg_q.max_force};
			REG_APPLY_RATE:     prdata = {16'd0, cfg_q.apply_rate};
			REG_RELEASE_RATE:   prdata = {16'd0, cfg_q.release_rate};
			default:            prdata = '0;
		endcase
	end

endmodule

// ===== rtl/dbsc_dp.sv =====
// ----------------------------------------------------------------------------
// dbsc_dp
// Datapath: gate check, radix-2 divider, bitwise square root, one shared
// 16x16 multiplier, balance slew and the result register.
// ----------------------------------------------------------------------------
module dbsc_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  dbsc_pkg::cfg_t     cfg,
	input  dbsc_pkg::item_t    item,
	input  dbsc_pkg::dp_cmd_t  cmd,
	output dbsc_pkg::dp_stat_t stat,
	output dbsc_pkg::result_t  result
);
	import dbsc_pkg::*;

	logic [14:0]        mag_q;
	logic               neg_q;
	logic [15:0]        elapsed_q;
	logic               active_q;
	logic [16:0]        rem_q;
	logic [14:0]        quo_q;
	logic [29:0]        v_q;
	logic [29:0]        res_q;
	logic [29:0]        bit_q;
	logic [31:0]        prod_q;
	logic [14:0]        tmag_q;
	logic signed [15:0] bal_q;
	result_t            result_q;

	logic               slow;
	logic               active_d;
	logic [15:0]        neg_raw;
	logic [14:0]        mag_d;
	logic [15:0]        den;
	logic [16:0]        rem2;
	logic               div_ge;
	logic [30:0]        sq_sum;
	logic               sq_ge;
	logic [15:0]        mul_a;
	logic [15:0]        mul_b;
	logic [31:0]        prod_d;
	logic [15:0]        bmag;
	logic [15:0]        rate;
	logic signed [17:0] maxd;
	logic signed [17:0] tgt;
	logic signed [17:0] delta;
	logic signed [17:0] dcl;
	logic signed [17:0] bsum;
	logic signed [15:0] bal_d;

	// Gate on the incoming item.
	always_comb begin
		case (cfg.gate_source)
			GATE_SPEED:    slow = item.ground_speed <= cfg.speed_limit;
			GATE_THROTTLE: slow = item.throttle <= cfg.throttle_limit;
			default:       slow = 1'b0;
		endcase
	end
	assign active_d = cfg.enable & item.on_ground & slow;

	// The most negative rudder value saturates to full positive magnitude.
	assign neg_raw = 16'(~item.rudder + 16'd1);
	assign mag_d   = item.rudder[15] ? (neg_raw[15] ? 15'h7FFF : neg_raw[14:0])
	                                 : item.rudder[14:0];

	assign stat.active  = active_q;
	assign stat.in_zone = mag_q <= cfg.deadzone;

	// Divider: the remainder always stays below the divisor.
	assign den    = 16'h8000 - {1'b0, cfg.deadzone};
	assign rem2   = {rem_q[15:0], 1'b0};
	assign div_ge = rem2 >= {1'b0, den};

	// Square root.
	assign sq_sum = {1'b0, res_q} + {1'b0, bit_q};
	assign sq_ge  = {1'b0, v_q} >= sq_sum;

	// Shared multiplier operands.
	assign bmag = bal_q[15] ? 16'(-bal_q) : 16'(bal_q);
	assign rate = ({1'b0, prod_q[29:15]} < bmag) ? cfg.release_rate : cfg.apply_rate;

	always_comb begin
		mul_a = rate;
		mul_b = elapsed_q;
		if (cmd.mul1) begin
			mul_a = {1'b0, quo_q};
			mul_b = {1'b0, res_q[14:0]};
		end else if (cmd.mul2) begin
			mul_a = {1'b0, prod_q[29:15]};
			mul_b = {1'b0, cfg.max_force};
		end
	end
	assign prod_d = mul_a * mul_b;

	// Balance slew and saturation.
	assign maxd  = $signed({2'b00, prod_q[31:16]});
	assign tgt   = neg_q ? -$signed({3'b000, tmag_q}) : $signed({3'b000, tmag_q});
	assign delta = tgt - 18'(bal_q);

	always_comb begin
		dcl = delta;
		if (delta > maxd) begin
			dcl = maxd;
		end else if (delta < -maxd) begin
			dcl = -maxd;
		end
		bsum = 18'(bal_q) + dcl;
		if (bsum > 18'sd32767) begin
			bal_d = 16'sd32767;
		end else if (bsum < -18'sd32767) begin
			bal_d = -16'sd32767;
		end else begin
			bal_d = bsum[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bal_q    <= '0;
			active_q <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				active_q <= active_d;
			end
			if (cmd.clr_bal) begin
				bal_q <= '0;
			end else if (cmd.update) begin
				bal_q <= bal_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mag_q     <= mag_d;
			neg_q     <= item.rudder[15];
			elapsed_q <= item.elapsed;
		end
		if (cmd.div_init) begin
			rem_q <= 17'(mag_q - cfg.deadzone);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? (rem2 - {1'b0, den}) : rem2;
			quo_q <= {quo_q[13:0], div_ge};
		end
		if (cmd.sq_init) begin
			v_q   <= {quo_q, 15'd0};
			res_q <= '0;
			bit_q <= SQ_BIT0;
		end else if (cmd.sq_step) begin
			if (sq_ge) begin
				v_q   <= v_q - sq_sum[29:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.zero_prod) begin
			prod_q <= '0;
		end else if (cmd.mul1 | cmd.mul2 | cmd.mul3) begin
			prod_q <= prod_d;
		end
		if (cmd.mul3) begin
			tmag_q <= prod_q[29:15];
		end
		if (cmd.load_out) begin
			result_q.left_brake     <= bal_q[15] ? 15'(-bal_q) : 15'd0;
			result_q.right_brake    <= bal_q[15] ? 15'd0 : bal_q[14:0];
			result_q.braking_active <= active_q;
		end
	end

	assign result = result_q;

endmodule

// ===== rtl/dbsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dbsc_ctrl
// Controller: sequences the datapath for one item and owns both handshakes.
// ----------------------------------------------------------------------------
module dbsc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  dbsc_pkg::dp_stat_t stat,
	output dbsc_pkg::dp_cmd_t  cmd
);
	import dbsc_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_LOAD  = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_SINIT = 4'd3;
	localparam logic [3:0] ST_SQRT  = 4'd4;
	localparam logic [3:0] ST_MUL1  = 4'd5;
	localparam logic [3:0] ST_MUL2  = 4'd6;
	localparam logic [3:0] ST_MUL3  = 4'd7;
	localparam logic [3:0] ST_UPD   = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [3:0] cnt_q;
	logic       out_valid_q;
	logic       out_free;

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (!stat.active) begin
					cmd.clr_bal = 1'b1;
					state_d     = ST_FIN;
				end else if (stat.in_zone) begin
					// Target is zero: skip straight to the slew.
					cmd.zero_prod = 1'b1;
					state_d       = ST_MUL3;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == LAST_ITER) begin
					state_d = ST_SINIT;
				end
			end
			ST_SINIT: begin
				cmd.sq_init = 1'b1;
				state_d     = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sq_step = 1'b1;
				if (cnt_q == LAST_ITER) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_MUL3;
			end
			ST_MUL3: begin
				cmd.mul3 = 1'b1;
				state_d  = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_step || cmd.sq_step) begin
				cnt_q <= (cnt_q == LAST_ITER) ? 4'd0 : cnt_q + 4'd1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/differential_brake_slew_controller_core.sv =====
// ----------------------------------------------------------------------------
// differential_brake_slew_controller_core
// Turns a rudder command into slew-limited left and right brake forces.
//
// One input item per control tick arrives on the s_ stream: rudder, ground
// speed, throttle and elapsed time in tdata, the on-ground flag in tuser.
// Each item gives one result item on the m_ stream: left and right brake in
// tdata, the braking-active flag in tuser. The user must see that registers
// are written through the APB-style port only while no item is in flight;
// the block does not enforce this. pready is always high. An item is taken
// only once the last one is done. An active item runs the 15-step divider,
// the 15-step square root, the multiplies and the update; in the deadzone
// only the slew runs. m_tvalid rises in the cycle after a result is loaded.
// One result register sits on the output: the next item is accepted while a
// result waits, and its own result is held back until the receiver takes the
// earlier one. Reset clears the balance, the state and the output valid and
// loads the default register values.
// ----------------------------------------------------------------------------
module differential_brake_slew_controller_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dbsc_pkg::ADDR_W-1:0] paddr,
	input  logic [dbsc_pkg::DATA_W-1:0] pwdata,
	output logic [dbsc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// rudder [15:0], ground_speed [31:16], throttle [47:32], elapsed [63:48]
	input  logic [63:0]                 s_tdata,
	// on_ground [0]
	input  logic [0:0]                  s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// left_brake [14:0], right_brake [29:15], zero [31:30]
	output logic [31:0]                 m_tdata,
	// braking_active [0]
	output logic [0:0]                  m_tuser
);
	import dbsc_pkg::*;

	cfg_t     cfg;
	item_t    item;
	dp_cmd_t  cmd;
	dp_stat_t stat;
	result_t  result;

	assign item.rudder       = s_tdata[15:0];
	assign item.on_ground    = s_tuser[0];
	assign item.ground_speed = s_tdata[31:16];
	assign item.throttle     = s_tdata[47:32];
	assign item.elapsed      = s_tdata[63:48];

	assign m_tdata = {2'b00, result.right_brake, result.left_brake};
	assign m_tuser = result.braking_active;

	dbsc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dbsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dbsc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule
